[hw/rtl/wfbs_pkg.sv]
// ----------------------------------------------------------------------------
// Wire-format byte scanner package
// Shared codes, reset values and the per-byte result type.
// ----------------------------------------------------------------------------
package wfbs_pkg;

  // Parser phase codes
  localparam logic [2:0] PhTag     = 3'd0;
  localparam logic [2:0] PhVarint  = 3'd1;
  localparam logic [2:0] PhLen     = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhI32     = 3'd4;

  // Byte role codes
  localparam logic [2:0] RolePad     = 3'd0;
  localparam logic [2:0] RoleTag     = 3'd1;
  localparam logic [2:0] RoleVarint  = 3'd2;
  localparam logic [2:0] RoleLen     = 3'd3;
  localparam logic [2:0] RolePayload = 3'd4;
  localparam logic [2:0] RoleI32     = 3'd5;
  localparam logic [2:0] RoleIgnored = 3'd6;

  // Wire kind codes as reported
  localparam logic [1:0] KindVarint  = 2'd0;
  localparam logic [1:0] KindLenDel  = 2'd1;
  localparam logic [1:0] KindI32     = 2'd2;
  localparam logic [1:0] KindUnknown = 2'd3;

  // Low three tag bits
  localparam logic [2:0] TagVarint = 3'b000;
  localparam logic [2:0] TagLenDel = 3'b010;
  localparam logic [2:0] TagI32    = 3'b101;

  localparam logic [31:0] StopOffsetReset = 32'h00FF_FFFF;
  localparam logic [7:0]  PrintLow        = 8'd32;
  localparam logic [7:0]  PrintHigh       = 8'd126;
  localparam logic [7:0]  DotChar         = 8'h2E;

  localparam int unsigned TdataInWidth  = 8;
  localparam int unsigned TdataOutWidth = 120;
  localparam int unsigned TuserOutWidth = 5;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [2:0]  byte_role;
    logic [1:0]  wire_kind;
    logic [4:0]  field_number;
    logic [7:0]  index_in_field;
    logic [7:0]  display_char;
    logic [31:0] value_word;
    logic        field_done;
    logic        truncated;
    logic [31:0] unknown_total;
    logic        stopped;
  } result_t;

endpackage

[hw/rtl/wire_format_byte_scanner.sv]
// ----------------------------------------------------------------------------
// Wire-format byte scanner
// Labels every byte of a simplified protobuf-like stream with its role.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle unless the sink stalls it and
// returns exactly one result item per byte, in order. A byte is captured in
// the input register, labeled by single-pass logic against the parser state
// and stored in the result register, so a result is presented once its byte
// has passed both registers. Both registers advance together whenever the
// result register is empty or being drained, which keeps the rate at one item
// per cycle under a ready sink. The user must write the stop offset through
// cfg_we_i only while no byte is in flight; the block does not enforce this.
module wire_format_byte_scanner (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: data_byte[7:0]
  input  logic [wfbs_pkg::TdataInWidth-1:0]  s_axis_tdata,
  // tlast: final_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: byte_offset[31:0], field_number[36:32], index_in_field[44:37],
  // display_char[52:45], value_word[84:53], truncated[85],
  // unknown_total[117:86], stopped[118], zero fill[119]
  output logic [wfbs_pkg::TdataOutWidth-1:0] m_axis_tdata,
  // tuser: byte_role[2:0], wire_kind[4:3]
  output logic [wfbs_pkg::TuserOutWidth-1:0] m_axis_tuser,
  // tlast: field_done
  output logic         m_axis_tlast
);
  import wfbs_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  wfbs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (advance),
    .data_byte_i  (in_byte_q),
    .final_byte_i (in_last_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.field_done;
  assign m_axis_tuser  = {out_q.wire_kind, out_q.byte_role};
  assign m_axis_tdata  = {1'b0, out_q.stopped, out_q.unknown_total, out_q.truncated,
                          out_q.value_word, out_q.display_char, out_q.index_in_field,
                          out_q.field_number, out_q.byte_offset};

endmodule

[hw/rtl/wfbs_core.sv]
// ----------------------------------------------------------------------------
// Wire-format byte scanner core
// Parser state registers and the single-pass labeling logic for one byte.
// ----------------------------------------------------------------------------
module wfbs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output wfbs_pkg::result_t res_o
);
  import wfbs_pkg::*;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] offset;
    logic [7:0]  bytes_left;
    logic [7:0]  position;
    logic [4:0]  held_field;
    logic [1:0]  held_kind;
    logic [23:0] word;
    logic [31:0] unknown_count;
    logic        halted;
  } state_t;

  state_t      st_q, st_d;
  logic [31:0] stop_q;
  result_t     res;
  logic        done;

  always_comb begin
    st_d = st_q;
    done = 1'b0;
    res.byte_offset    = st_q.offset;
    res.byte_role      = RoleIgnored;
    res.wire_kind      = st_q.held_kind;
    res.field_number   = st_q.held_field;
    res.index_in_field = '0;
    res.display_char   = '0;
    res.value_word     = {24'd0, data_byte_i};
    res.truncated      = 1'b0;

    st_d.offset = st_q.offset + 32'd1;

    if (!st_q.halted) begin
      case (st_q.phase)
        PhVarint: begin
          res.byte_role = RoleVarint;
          done          = 1'b1;
        end
        PhLen: begin
          res.byte_role   = RoleLen;
          st_d.bytes_left = data_byte_i;
          st_d.position   = '0;
          if (data_byte_i == 8'd0) begin
            done = 1'b1;
          end else begin
            st_d.phase = PhPayload;
          end
        end
        PhPayload: begin
          res.byte_role      = RolePayload;
          res.index_in_field = st_q.position;
          res.display_char   = (data_byte_i inside {[PrintLow:PrintHigh]}) ?
                               data_byte_i : DotChar;
          st_d.position      = st_q.position + 8'd1;
          st_d.bytes_left    = st_q.bytes_left - 8'd1;
          // The count reaches zero on this byte when it stood at one.
          if (st_q.bytes_left == 8'd1) begin
            done = 1'b1;
          end
        end
        PhI32: begin
          res.byte_role      = RoleI32;
          res.index_in_field = {6'd0, st_q.position[1:0]};
          if (st_q.position[1:0] == 2'd3) begin
            res.value_word = {data_byte_i, st_q.word};
            done           = 1'b1;
          end else begin
            case (st_q.position[1:0])
              2'd0:    st_d.word[7:0]   = data_byte_i;
              2'd1:    st_d.word[15:8]  = data_byte_i;
              default: st_d.word[23:16] = data_byte_i;
            endcase
            st_d.position = {6'd0, st_q.position[1:0] + 2'd1};
          end
        end
        default: begin
          if (data_byte_i == 8'd0) begin
            res.byte_role    = RolePad;
            res.wire_kind    = KindVarint;
            res.field_number = '0;
          end else begin
            res.byte_role   = RoleTag;
            st_d.held_field = data_byte_i[7:3];
            st_d.position   = '0;
            st_d.word       = '0;
            st_d.bytes_left = '0;
            case (data_byte_i[2:0])
              TagVarint: begin
                st_d.held_kind = KindVarint;
                st_d.phase     = PhVarint;
              end
              TagLenDel: begin
                st_d.held_kind = KindLenDel;
                st_d.phase     = PhLen;
              end
              TagI32: begin
                st_d.held_kind = KindI32;
                st_d.phase     = PhI32;
              end
              default: begin
                st_d.held_kind     = KindUnknown;
                st_d.unknown_count = st_q.unknown_count + 32'd1;
                done               = 1'b1;
              end
            endcase
            res.field_number = st_d.held_field;
            res.wire_kind    = st_d.held_kind;
          end
        end
      endcase

      if (done) begin
        st_d.phase      = PhTag;
        st_d.position   = '0;
        st_d.bytes_left = '0;
        st_d.word       = '0;
        if (st_d.offset >= stop_q) begin
          st_d.halted = 1'b1;
        end
      end

      if (final_byte_i) begin
        res.truncated   = (st_d.phase != PhTag);
        st_d.phase      = PhTag;
        st_d.position   = '0;
        st_d.bytes_left = '0;
        st_d.word       = '0;
      end
    end

    res.field_done    = done;
    res.unknown_total = st_d.unknown_count;
    res.stopped       = st_d.halted;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      stop_q <= StopOffsetReset;
    end else begin
      if (step_i) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        stop_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[hw/rtl/wfbs_checker.sv]
// ----------------------------------------------------------------------------
// Wire-format byte scanner checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wfbs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [wfbs_pkg::TdataOutWidth-1:0] m_axis_tdata,
  input logic [wfbs_pkg::TuserOutWidth-1:0] m_axis_tuser,
  input logic                               m_axis_tlast
);
  import wfbs_pkg::*;

  logic        out_acc;
  logic        seen_q;
  logic [31:0] prev_off_q;
  logic        prev_stop_q;
  logic [2:0]  role;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign role    = m_axis_tuser[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_off_q  <= '0;
      prev_stop_q <= 1'b0;
    end else if (out_acc) begin
      seen_q      <= 1'b1;
      prev_off_q  <= m_axis_tdata[31:0];
      prev_stop_q <= m_axis_tdata[118];
    end
  end

  // A stalled result must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Offsets of delivered items count up by one with no gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> m_axis_tdata[31:0] == prev_off_q + 32'd1)
    else $error("byte offset skipped or repeated");

  // Once stopped, every later byte is ignored and stays stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_stop_q |-> m_axis_tdata[118] && role == RoleIgnored)
    else $error("byte parsed after stop");

  // Padding and ignored bytes never complete a field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> role != RolePad && role != RoleIgnored)
    else $error("field completion on padding or ignored byte");

  // The display character is only set on payload bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && role != RolePayload |-> m_axis_tdata[52:45] == 8'd0)
    else $error("display character outside payload");

endmodule

bind wire_format_byte_scanner wfbs_checker u_wfbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[test/wfbs_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wire-format byte scanner checker
// Watches both streams, labels every accepted byte and compares the results.
// ----------------------------------------------------------------------------
// Every byte accepted on the input stream is labeled by a local copy of the
// scanner state and queued. Every result taken from the output stream is
// unpacked and compared field by field with the oldest queued label.
module wfbs_tb_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [31:0]                        cfg_wdata_i,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  input  logic [wfbs_pkg::TdataInWidth-1:0]  s_tdata_i,
  input  logic                               s_tlast_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  input  logic [wfbs_pkg::TdataOutWidth-1:0] m_tdata_i,
  input  logic [wfbs_pkg::TuserOutWidth-1:0] m_tuser_i,
  input  logic                               m_tlast_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o,
  output int                                 compared_o
);
  import wfbs_pkg::*;

  logic [31:0] stop_at;
  logic [2:0]  phase;
  logic [31:0] offset;
  logic [7:0]  left;
  logic [7:0]  pos;
  logic [4:0]  field_held;
  logic [1:0]  kind_held;
  logic [23:0] assembly;
  logic [31:0] unknown_cnt;
  logic        halted;

  result_t labels_due[$];
  result_t want_r;
  result_t got_r;
  int      mismatches;
  int      compared;

  assign mismatch_count_o = mismatches;
  assign compared_o       = compared;

  task automatic note_mismatch(input string what, input logic [31:0] at,
                               input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch in %s at offset %0d: got 0x%h, expected 0x%h",
             $time, what, at, got, want);
  endtask

  // Labels one stream byte and advances the scanner state.
  task automatic label_byte(input logic [7:0] b, input logic fin, output result_t r);
    logic done;
    r = '0;
    done = 1'b0;
    r.byte_offset  = offset;
    r.byte_role    = RoleIgnored;
    r.wire_kind    = kind_held;
    r.field_number = field_held;
    r.value_word   = {24'd0, b};
    offset = offset + 32'd1;
    if (!halted) begin
      case (phase)
        PhVarint: begin
          r.byte_role = RoleVarint;
          done = 1'b1;
        end
        PhLen: begin
          r.byte_role = RoleLen;
          left = b;
          pos = 8'd0;
          if (b == 8'd0) begin
            done = 1'b1;
          end else begin
            phase = PhPayload;
          end
        end
        PhPayload: begin
          r.byte_role      = RolePayload;
          r.index_in_field = pos;
          r.display_char   = (b >= PrintLow && b <= PrintHigh) ? b : DotChar;
          pos  = pos + 8'd1;
          left = left - 8'd1;
          if (left == 8'd0) done = 1'b1;
        end
        PhI32: begin
          r.byte_role      = RoleI32;
          r.index_in_field = {6'd0, pos[1:0]};
          if (pos[1:0] == 2'd3) begin
            r.value_word = {b, assembly};
            done = 1'b1;
          end else begin
            assembly = assembly | (24'(b) << (8 * pos[1:0]));
            pos = {6'd0, pos[1:0]} + 8'd1;
          end
        end
        default: begin
          if (b == 8'd0) begin
            r.byte_role    = RolePad;
            r.wire_kind    = KindVarint;
            r.field_number = 5'd0;
          end else begin
            r.byte_role = RoleTag;
            field_held = b[7:3];
            pos = 8'd0;
            assembly = 24'd0;
            left = 8'd0;
            case (b[2:0])
              TagVarint: begin
                kind_held = KindVarint;
                phase = PhVarint;
              end
              TagLenDel: begin
                kind_held = KindLenDel;
                phase = PhLen;
              end
              TagI32: begin
                kind_held = KindI32;
                phase = PhI32;
              end
              default: begin
                kind_held = KindUnknown;
                unknown_cnt = unknown_cnt + 32'd1;
                done = 1'b1;
              end
            endcase
            r.wire_kind    = kind_held;
            r.field_number = field_held;
          end
        end
      endcase
      if (done) begin
        phase = PhTag;
        pos = 8'd0;
        left = 8'd0;
        assembly = 24'd0;
        if (offset >= stop_at) halted = 1'b1;
      end
      // A final byte always returns the parser to the tag state.
      if (fin) begin
        r.truncated = (phase != PhTag);
        phase = PhTag;
        pos = 8'd0;
        left = 8'd0;
        assembly = 24'd0;
      end
    end
    r.field_done    = done;
    r.unknown_total = unknown_cnt;
    r.stopped       = halted;
  endtask

  task automatic compare_label(input result_t got, input result_t want);
    logic [31:0] at;
    at = want.byte_offset;
    if (got.byte_offset !== want.byte_offset)
      note_mismatch("byte_offset", at, got.byte_offset, want.byte_offset);
    if (got.byte_role !== want.byte_role)
      note_mismatch("byte_role", at, 32'(got.byte_role), 32'(want.byte_role));
    if (got.wire_kind !== want.wire_kind)
      note_mismatch("wire_kind", at, 32'(got.wire_kind), 32'(want.wire_kind));
    if (got.field_number !== want.field_number)
      note_mismatch("field_number", at, 32'(got.field_number), 32'(want.field_number));
    if (got.index_in_field !== want.index_in_field)
      note_mismatch("index_in_field", at, 32'(got.index_in_field),
                    32'(want.index_in_field));
    if (got.display_char !== want.display_char)
      note_mismatch("display_char", at, 32'(got.display_char), 32'(want.display_char));
    if (got.value_word !== want.value_word)
      note_mismatch("value_word", at, got.value_word, want.value_word);
    if (got.field_done !== want.field_done)
      note_mismatch("field_done", at, 32'(got.field_done), 32'(want.field_done));
    if (got.truncated !== want.truncated)
      note_mismatch("truncated", at, 32'(got.truncated), 32'(want.truncated));
    if (got.unknown_total !== want.unknown_total)
      note_mismatch("unknown_total", at, got.unknown_total, want.unknown_total);
    if (got.stopped !== want.stopped)
      note_mismatch("stopped", at, 32'(got.stopped), 32'(want.stopped));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_at     = StopOffsetReset;
      phase       = PhTag;
      offset      = 32'd0;
      left        = 8'd0;
      pos         = 8'd0;
      field_held  = 5'd0;
      kind_held   = KindVarint;
      assembly    = 24'd0;
      unknown_cnt = 32'd0;
      halted      = 1'b0;
      labels_due.delete();
      mismatches  = 0;
      compared    = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) stop_at = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        label_byte(s_tdata_i[7:0], s_tlast_i, want_r);
        labels_due.push_back(want_r);
      end
      if (m_tvalid_i && m_tready_i) begin
        got_r.byte_offset    = m_tdata_i[31:0];
        got_r.field_number   = m_tdata_i[36:32];
        got_r.index_in_field = m_tdata_i[44:37];
        got_r.display_char   = m_tdata_i[52:45];
        got_r.value_word     = m_tdata_i[84:53];
        got_r.truncated      = m_tdata_i[85];
        got_r.unknown_total  = m_tdata_i[117:86];
        got_r.stopped        = m_tdata_i[118];
        got_r.byte_role      = m_tuser_i[2:0];
        got_r.wire_kind      = m_tuser_i[4:3];
        got_r.field_done     = m_tlast_i;
        if (labels_due.size() == 0) begin
          note_mismatch("result with nothing pending", got_r.byte_offset, 32'd0, 32'd0);
        end else begin
          want_r = labels_due.pop_front();
          compare_label(got_r, want_r);
          compared++;
        end
      end
      pending_o = labels_due.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wire-format byte scanner testbench
// Drives byte streams with random flow control and reports the verdict.
// ----------------------------------------------------------------------------
// A short directed stream covers every field kind, zero length, printable
// limits, unknown tags and both clean and truncated stream ends. Random
// streams of mostly well-formed fields follow under three flow-control
// mixes, one with a full-length payload, and a last stream runs with a zero
// stop offset so that the scanner halts and ignores the rest.
module tb_top;
  import wfbs_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [31:0]              cfg_wdata = 32'd0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [TdataInWidth-1:0]  s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [TdataOutWidth-1:0] m_tdata;
  logic [TuserOutWidth-1:0] m_tuser;
  logic                     m_tlast;

  int mismatches;
  int pending;
  int compared;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int bytes_sent = 0;

  logic [7:0] stream_q[$];
  logic       stream_last_q[$];

  // Directed stream, {final, byte}: padding, a varint ending a stream
  // cleanly, a length-delimited field around the printable limits, a zero
  // length, an i32 word, two unknown tags, a truncated i32, a truncated tag
  // and a final padding byte.
  localparam logic [8:0] Directed [23] = '{
    9'h000, 9'h008, 9'h1FF,
    9'h0FA, 9'h004, 9'h01F, 9'h020, 9'h07E, 9'h07F,
    9'h012, 9'h000,
    9'h00D, 9'h078, 9'h056, 9'h034, 9'h012,
    9'h001, 9'h0FF,
    9'h015, 9'h0AA, 9'h1BB,
    9'h108, 9'h100
  };

  always #1 clk = ~clk;

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

  wire_format_byte_scanner dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  wfbs_tb_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .m_tlast_i        (m_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .compared_o       (compared)
  );

  task automatic queue_byte(input logic [7:0] b, input logic last);
    stream_q.push_back(b);
    stream_last_q.push_back(last);
  endtask

  // Appends one random field, now and then cut short or ending the stream.
  task automatic add_field();
    logic [7:0] part[$];
    int         pick;
    int         len;
    int         cut;
    logic [4:0] fnum;
    logic [2:0] low;
    pick = $urandom_range(0, 99);
    fnum = 5'($urandom_range(1, 31));
    if (pick < 8) begin
      part.push_back(8'h00);
    end else if (pick < 28) begin
      part.push_back({fnum, TagVarint});
      part.push_back(8'($urandom));
    end else if (pick < 52) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      part.push_back({fnum, TagLenDel});
      part.push_back(8'(len));
      repeat (len) begin
        part.push_back($urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom));
      end
    end else if (pick < 76) begin
      part.push_back({fnum, TagI32});
      repeat (4) part.push_back(8'($urandom));
    end else if (pick < 86) begin
      do low = 3'($urandom); while (low == TagVarint || low == TagLenDel || low == TagI32);
      part.push_back({fnum, low});
    end else begin
      repeat ($urandom_range(1, 4)) part.push_back(8'($urandom));
    end
    cut = part.size();
    if ($urandom_range(0, 99) < 5 && cut > 1) cut = $urandom_range(1, cut - 1);
    for (int i = 0; i < cut; i++) begin
      queue_byte(part[i], (i == cut - 1) &&
                          (cut != part.size() || $urandom_range(0, 99) < 6));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    // Ready only moves at rising edges, so its value at the falling edge
    // decides the next edge.
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front(), stream_last_q.pop_front());
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_stop(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_stream(input int count);
    while (stream_q.size() < count) add_field();
    send_stream();
  endtask

  initial begin
    #1_000_000;
    $display("wire_format_byte_scanner test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct  = 30;
    sink_idle_pct = 85;
    foreach (Directed[i]) queue_byte(Directed[i][7:0], Directed[i][8]);
    send_stream();

    set_stop(32'hFFFF_FFFF);
    random_stream(50);

    src_idle_pct  = 85;
    sink_idle_pct = 30;
    set_stop($urandom | 32'h0010_0000);
    random_stream(50);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_stop(32'hFFFF_FFFF);
    // One payload of the full length brings the payload index to its highest value, 254.
    queue_byte({5'd9, TagLenDel}, 1'b0);
    queue_byte(8'd255, 1'b0);
    repeat (255) queue_byte(8'($urandom), 1'b0);
    random_stream(270);

    // With a zero stop offset the first completed field halts the scanner.
    set_stop(32'd0);
    random_stream(20);

    repeat (8) @(posedge clk);
    $display("Sent %0d stream bytes under four stop offsets and three flow-control mixes,",
             bytes_sent);
    $display("and compared %0d labeled results.", compared);
    if (mismatches == 0 && pending == 0) begin
      $display("wire_format_byte_scanner test passed");
    end else begin
      $display("wire_format_byte_scanner test failed");
    end
    $finish;
  end

endmodule
